// ===== rtl/gut_pkg.sv =====
// gut_pkg: shared types and constants of the gps/unix time converter
// transaction payload structs, field widths, codes and conversion constants
// no dependencies
package gut_pkg;

    localparam int FUNC_W   = 1;
    localparam int UNIT_W   = 1;
    localparam int WEEK_W   = 18;
    localparam int TOW_W    = 30;
    localparam int UMS_W    = 47;
    localparam int UMS_O_W  = 49;
    localparam int WEEK_O_W = 20;

    localparam int EPOCH_W  = 40;
    localparam int LEAP_W   = 8;
    localparam int CFG_W    = 40;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAP  = 1'b1;

    localparam logic FUNC_TO_UNIX = 1'b0;
    localparam logic FUNC_TO_GPS  = 1'b1;
    localparam logic UNIT_SEC     = 1'b0;
    localparam logic UNIT_MS      = 1'b1;

    localparam logic [EPOCH_W-1:0] EPOCH_RST = 40'd315964800;
    localparam logic [LEAP_W-1:0]  LEAP_RST  = 8'd18;

    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
    localparam logic [19:0] SEC_PER_WEEK = 20'd604800;
    localparam logic [29:0] MS_PER_WEEK  = 30'd604800000;

    // unix ms / 1000: split at bit 24, then reciprocal multiply of the folded low part
    localparam int MS_REM_W  = 10;
    localparam int SECS_W    = 38;
    localparam int MS_LO_W   = 24;
    localparam int MS_HI_W   = UMS_W - MS_LO_W;
    localparam int MS_Y_W    = 31;
    localparam int MS_PRE_SH = 3;
    localparam int MS_RCP_SH = 35;
    localparam int MS_RCP_W  = 29;
    localparam int MS_P_W    = MS_Y_W - MS_PRE_SH + MS_RCP_W;
    localparam int MS_Q2_W   = MS_P_W - MS_RCP_SH;
    localparam logic [14:0] MS_HI_Q = 15'((64'd1 << MS_LO_W) / 64'(MS_PER_SEC));
    localparam logic [7:0]  MS_HI_R = 8'((64'd1 << MS_LO_W) % 64'(MS_PER_SEC));
    localparam logic [MS_RCP_W-1:0] MS_RCP =
        MS_RCP_W'((64'd1 << MS_RCP_SH) / (64'(MS_PER_SEC) >> MS_PRE_SH) + 64'd1);

    // week divider works on seconds biased to stay non-negative
    localparam int WK_REM_W       = 20;
    localparam int GPS_S_W        = 43;
    localparam int WEEK_BIAS_LOG2 = 22;
    localparam logic [GPS_S_W-1:0] WEEK_BIAS =
        GPS_S_W'(64'd604800 << WEEK_BIAS_LOG2);

    // 604800 = 128 * 4725: drop the low 7 bits, split at bit 18, reciprocal multiply
    localparam int WK_PRE_SH = 7;
    localparam int WK_ODD_W  = 13;
    localparam logic [WK_ODD_W-1:0] WK_ODD = WK_ODD_W'(SEC_PER_WEEK >> WK_PRE_SH);
    localparam int WK_U_W    = GPS_S_W - WK_PRE_SH;
    localparam int WK_LO_W   = 18;
    localparam int WK_HI_W   = WK_U_W - WK_LO_W;
    localparam int WK_V_W    = 30;
    localparam int WK_RCP_SH = 43;
    localparam int WK_RCP_W  = 31;
    localparam int WK_P_W    = WK_V_W + WK_RCP_W;
    localparam int WK_Q2_W   = WK_P_W - WK_RCP_SH;
    localparam int WK_QUO_W  = 24;
    localparam logic [5:0]  WK_HI_Q = 6'((64'd1 << WK_LO_W) / 64'(WK_ODD));
    localparam logic [11:0] WK_HI_R = 12'((64'd1 << WK_LO_W) % 64'(WK_ODD));
    localparam logic [WK_RCP_W-1:0] WK_RCP =
        WK_RCP_W'((64'd1 << WK_RCP_SH) / 64'(WK_ODD) + 64'd1);

    typedef struct packed {
        logic              func;
        logic              time_unit;
        logic [WEEK_W-1:0] gps_week;
        logic [TOW_W-1:0]  time_in_week;
        logic [UMS_W-1:0]  unix_ms;
    } t_in;

    typedef struct packed {
        logic signed [UMS_O_W-1:0]  unix_ms_out;
        logic signed [WEEK_O_W-1:0] gps_week_out;
        logic        [TOW_W-1:0]    time_in_week_out;
    } t_out;

    // fields that ride along the divider pipelines
    typedef struct packed {
        logic                func;
        logic                time_unit;
        logic [WEEK_W-1:0]   gps_week;
        logic [TOW_W-1:0]    time_in_week;
        logic [MS_REM_W-1:0] rem_ms;
    } t_side;

endpackage

// ===== rtl/gut_ms_div.sv =====
// gut_ms_div: three-stage divider of unix milliseconds by 1000 by reciprocal multiplication
// gives whole seconds and the millisecond remainder, carries side fields along
// depends on gut_pkg
module gut_ms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [gut_pkg::UMS_W-1:0]     i_dvd,
    input  gut_pkg::t_side                i_side,
    output logic                          o_vld,
    output logic [gut_pkg::SECS_W-1:0]    o_quo,
    output logic [gut_pkg::MS_REM_W-1:0]  o_rem,
    output gut_pkg::t_side                o_side
);
    import gut_pkg::*;

    logic                r_s1_vld;
    logic [SECS_W-1:0]   r_s1_qa;
    logic [MS_Y_W-1:0]   r_s1_y;
    t_side               r_s1_side;

    logic                r_s2_vld;
    logic [SECS_W-1:0]   r_s2_qa;
    logic [MS_Y_W-1:0]   r_s2_y;
    logic [MS_Q2_W-1:0]  r_s2_q2;
    t_side               r_s2_side;

    logic                r_s3_vld;
    logic [SECS_W-1:0]   r_s3_quo;
    logic [MS_REM_W-1:0] r_s3_rem;
    t_side               r_s3_side;

    logic [MS_HI_W-1:0]  n_hi;
    logic [SECS_W-1:0]   n_qa;
    logic [MS_Y_W-1:0]   n_y;
    logic [MS_P_W-1:0]   n_prod;
    logic [MS_Y_W-1:0]   n_rfull;
    logic [SECS_W-1:0]   n_quo;

    // x = hi * 2^24 + lo, folded to y = hi * (2^24 mod 1000) + lo
    always_comb begin
        n_hi    = i_dvd[UMS_W-1:MS_LO_W];
        n_qa    = SECS_W'(n_hi) * SECS_W'(MS_HI_Q);
        n_y     = MS_Y_W'(n_hi) * MS_Y_W'(MS_HI_R) + MS_Y_W'(i_dvd[MS_LO_W-1:0]);
        n_prod  = MS_P_W'(r_s1_y[MS_Y_W-1:MS_PRE_SH]) * MS_P_W'(MS_RCP);
        n_rfull = r_s2_y - MS_Y_W'(r_s2_q2) * MS_Y_W'(MS_PER_SEC);
        n_quo   = r_s2_qa + SECS_W'(r_s2_q2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_qa   <= n_qa;
        r_s1_y    <= n_y;
        r_s1_side <= i_side;
        r_s2_qa   <= r_s1_qa;
        r_s2_y    <= r_s1_y;
        r_s2_q2   <= n_prod[MS_P_W-1:MS_RCP_SH];
        r_s2_side <= r_s1_side;
        r_s3_quo  <= n_quo;
        r_s3_rem  <= n_rfull[MS_REM_W-1:0];
        r_s3_side <= r_s2_side;
    end

    assign o_vld  = r_s3_vld;
    assign o_quo  = r_s3_quo;
    assign o_rem  = r_s3_rem;
    assign o_side = r_s3_side;

endmodule

// ===== rtl/gut_week_div.sv =====
// gut_week_div: three-stage divider of biased gps seconds by 604800 by reciprocal multiplication
// gives the biased week count and the second of week, carries side fields along
// depends on gut_pkg
module gut_week_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [gut_pkg::GPS_S_W-1:0]   i_dvd,
    input  gut_pkg::t_side                i_side,
    output logic                          o_vld,
    output logic [gut_pkg::WK_QUO_W-1:0]  o_quo,
    output logic [gut_pkg::WK_REM_W-1:0]  o_rem,
    output gut_pkg::t_side                o_side
);
    import gut_pkg::*;

    logic                 r_s1_vld;
    logic [WK_QUO_W-1:0]  r_s1_qa;
    logic [WK_V_W-1:0]    r_s1_v;
    logic [WK_PRE_SH-1:0] r_s1_lo;
    t_side                r_s1_side;

    logic                 r_s2_vld;
    logic [WK_QUO_W-1:0]  r_s2_qa;
    logic [WK_V_W-1:0]    r_s2_v;
    logic [WK_Q2_W-1:0]   r_s2_q2;
    logic [WK_PRE_SH-1:0] r_s2_lo;
    t_side                r_s2_side;

    logic                 r_s3_vld;
    logic [WK_QUO_W-1:0]  r_s3_quo;
    logic [WK_REM_W-1:0]  r_s3_rem;
    t_side                r_s3_side;

    logic [WK_HI_W-1:0]   n_hi;
    logic [WK_LO_W-1:0]   n_lo;
    logic [WK_QUO_W-1:0]  n_qa;
    logic [WK_V_W-1:0]    n_v;
    logic [WK_P_W-1:0]    n_prod;
    logic [WK_V_W-1:0]    n_rfull;
    logic [WK_QUO_W-1:0]  n_quo;

    // u = seconds / 128 = hi * 2^18 + lo, folded to v = hi * (2^18 mod 4725) + lo
    always_comb begin
        n_hi    = i_dvd[GPS_S_W-1:WK_PRE_SH+WK_LO_W];
        n_lo    = i_dvd[WK_PRE_SH+WK_LO_W-1:WK_PRE_SH];
        n_qa    = WK_QUO_W'(n_hi) * WK_QUO_W'(WK_HI_Q);
        n_v     = WK_V_W'(n_hi) * WK_V_W'(WK_HI_R) + WK_V_W'(n_lo);
        n_prod  = WK_P_W'(r_s1_v) * WK_P_W'(WK_RCP);
        n_rfull = r_s2_v - WK_V_W'(r_s2_q2) * WK_V_W'(WK_ODD);
        n_quo   = r_s2_qa + WK_QUO_W'(r_s2_q2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_qa   <= n_qa;
        r_s1_v    <= n_v;
        r_s1_lo   <= i_dvd[WK_PRE_SH-1:0];
        r_s1_side <= i_side;
        r_s2_qa   <= r_s1_qa;
        r_s2_v    <= r_s1_v;
        r_s2_q2   <= n_prod[WK_P_W-1:WK_RCP_SH];
        r_s2_lo   <= r_s1_lo;
        r_s2_side <= r_s1_side;
        r_s3_quo  <= n_quo;
        r_s3_rem  <= {n_rfull[WK_ODD_W-1:0], r_s2_lo};
        r_s3_side <= r_s2_side;
    end

    assign o_vld  = r_s3_vld;
    assign o_quo  = r_s3_quo;
    assign o_rem  = r_s3_rem;
    assign o_side = r_s3_side;

endmodule

// ===== rtl/gut_result.sv =====
// gut_result: two-stage result builder
// forward sum of scaled epoch, week and time of week less leap seconds; reverse time of week
// depends on gut_pkg
module gut_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  gut_pkg::t_side                i_side,
    input  logic [gut_pkg::WEEK_O_W-1:0]  i_week,
    input  logic [gut_pkg::WK_REM_W-1:0]  i_sow,
    input  logic [gut_pkg::EPOCH_W-1:0]   i_epoch,
    input  logic [gut_pkg::LEAP_W-1:0]    i_leap,
    output logic                          o_strobe,
    output gut_pkg::t_out                 o_out
);
    import gut_pkg::*;

    logic                r_f1_vld;
    logic                r_f1_func;
    logic                r_f1_unit;
    logic [UMS_O_W-1:0]  r_epoch_ms;
    logic [UMS_O_W-1:0]  r_week_ms;
    logic [UMS_O_W-1:0]  r_tow_ms;
    logic [UMS_O_W-1:0]  r_leap_ms;
    logic [WEEK_O_W-1:0] r_week_out;
    logic [WK_REM_W-1:0] r_sow;
    logic [TOW_W-1:0]    r_sow_ms;
    logic [MS_REM_W-1:0] r_rem_ms;

    logic                r_strobe;
    t_out                r_out;

    logic [UMS_O_W-1:0]  n_sum;
    logic [TOW_W-1:0]    n_tow_out;
    t_out                n_out;

    // stage one: constant products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_func  <= i_side.func;
        r_f1_unit  <= i_side.time_unit;
        r_epoch_ms <= UMS_O_W'(i_epoch) * UMS_O_W'(MS_PER_SEC);
        r_week_ms  <= UMS_O_W'(i_side.gps_week) * UMS_O_W'(MS_PER_WEEK);
        if (i_side.time_unit == UNIT_SEC) begin
            r_tow_ms <= UMS_O_W'(i_side.time_in_week) * UMS_O_W'(MS_PER_SEC);
        end else begin
            r_tow_ms <= UMS_O_W'(i_side.time_in_week);
        end
        r_leap_ms  <= UMS_O_W'(i_leap) * UMS_O_W'(MS_PER_SEC);
        r_week_out <= i_week;
        r_sow      <= i_sow;
        r_sow_ms   <= TOW_W'(i_sow) * TOW_W'(MS_PER_SEC);
        r_rem_ms   <= i_side.rem_ms;
    end

    // stage two: sums and selection
    always_comb begin
        n_sum = r_epoch_ms + r_week_ms + r_tow_ms - r_leap_ms;
        if (r_f1_unit == UNIT_SEC) begin
            n_tow_out = TOW_W'(r_sow);
        end else begin
            n_tow_out = r_sow_ms + TOW_W'(r_rem_ms);
        end
        n_out = '0;
        if (r_f1_func == FUNC_TO_UNIX) begin
            n_out.unix_ms_out = n_sum;
        end else begin
            n_out.gps_week_out     = r_week_out;
            n_out.time_in_week_out = n_tow_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ===== rtl/gps_unix_time_converter.sv =====
// gps_unix_time_converter: top level of the gps week / unix millisecond converter
// input register, config registers, two divider pipelines and the result builder
// depends on gut_pkg, gut_ms_div, gut_week_div, gut_result
//
// usage
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low; busy stays low, so a transaction can be issued every cycle
//   result channel: o_strobe marks o_out for exactly one cycle, once the command has
//   passed every pipeline stage; one result per command, in command order
//   throughput: one transaction per cycle, set by the fully pipelined dividers
//   pipeline: input register, 3 stages of unix ms / 1000 (reciprocal multiply),
//   one seconds-rebase stage, 3 stages of / 604800, two result stages
//   config: write i_cfg_wdata to register i_cfg_idx (0 epoch seconds,
//   1 leap seconds) at an edge with i_cfg_we high, only while no command is in
//   flight
//   reset: synchronous, active low; clears the pipeline and loads the default
//   gps epoch and 18 leap seconds
//   the receiver cannot stall: each result must be taken in its strobe cycle
module gps_unix_time_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  gut_pkg::t_in                   i_in,
    input  logic                           i_cfg_we,
    input  logic [gut_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gut_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_strobe,
    output gut_pkg::t_out                  o_out
);
    import gut_pkg::*;

    logic [EPOCH_W-1:0]  r_epoch;
    logic [LEAP_W-1:0]   r_leap;

    logic                r_vld;
    t_in                 r_in;
    t_side               n_side;

    logic                ms_vld;
    logic [SECS_W-1:0]   ms_quo;
    logic [MS_REM_W-1:0] ms_rem;
    t_side               ms_side;

    logic                r_mid_vld;
    logic [GPS_S_W-1:0]  r_mid_dvd;
    t_side               r_mid_side;
    logic [GPS_S_W-1:0]  n_mid_dvd;
    t_side               n_mid_side;

    logic                wk_vld;
    logic [WK_QUO_W-1:0] wk_quo;
    logic [WK_REM_W-1:0] wk_rem;
    t_side               wk_side;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_RST;
            r_leap  <= LEAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EPOCH: r_epoch <= i_cfg_wdata[EPOCH_W-1:0];
                CFG_LEAP:  r_leap  <= i_cfg_wdata[LEAP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_in;
    end

    always_comb begin
        n_side.func         = r_in.func;
        n_side.time_unit    = r_in.time_unit;
        n_side.gps_week     = r_in.gps_week;
        n_side.time_in_week = r_in.time_in_week;
        n_side.rem_ms       = '0;
    end

    gut_ms_div u_ms_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_dvd   (r_in.unix_ms),
        .i_side  (n_side),
        .o_vld   (ms_vld),
        .o_quo   (ms_quo),
        .o_rem   (ms_rem),
        .o_side  (ms_side)
    );

    // gps seconds, biased by whole weeks so the floored division stays unsigned
    always_comb begin
        n_mid_dvd = WEEK_BIAS + GPS_S_W'(ms_quo)
                    - GPS_S_W'(r_epoch) + GPS_S_W'(r_leap);
        n_mid_side        = ms_side;
        n_mid_side.rem_ms = ms_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else begin
            r_mid_vld <= ms_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid_dvd  <= n_mid_dvd;
        r_mid_side <= n_mid_side;
    end

    gut_week_div u_week_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_mid_vld),
        .i_dvd   (r_mid_dvd),
        .i_side  (r_mid_side),
        .o_vld   (wk_vld),
        .o_quo   (wk_quo),
        .o_rem   (wk_rem),
        .o_side  (wk_side)
    );

    // the bias is a multiple of 2^20 weeks, so the low quotient bits are the week
    gut_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (wk_vld),
        .i_side   (wk_side),
        .i_week   (wk_quo[WEEK_O_W-1:0]),
        .i_sow    (wk_rem),
        .i_epoch  (r_epoch),
        .i_leap   (r_leap),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule
